// ----- rtl/core/vp9sfi_pkg.sv -----
// Package for the VP9 superframe index parser.
// Holds the index marker constants, window geometry and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package vp9sfi_pkg;

    localparam int WINDOW_BYTES = 34;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);

    localparam logic [7:0] MARKER_MASK = 8'he0;
    localparam logic [7:0] MARKER_VAL  = 8'hc0;
    localparam logic [2:0] FRAMES_MASK = 3'h7;
    localparam logic [1:0] BYTES_MASK  = 2'h3;
    localparam logic [5:0] MARKER_BYTES = 6'd2;

    typedef struct packed {
        logic [31:0] frame_size;
        logic [5:0]  index_size;
        logic        is_superframe;
        logic        parse_error;
        logic        last_of_run;
    } res_t;

endpackage

// ----- rtl/core/vp9_superframe_index_parser.sv -----
// VP9 superframe index parser: byte stream in, one frame size per transfer out.
// Depends on vp9sfi_pkg (marker constants, window geometry, result record).
`timescale 1ns / 1ps

// Bytes of a chunk are taken one per cycle while the block idles; each is written
// into a 34-entry circular tail window and counted (the count saturates at all ones).
// After the byte marked with s_tlast the block stops taking bytes and a small
// sequencer walks the index through the single registered read port of the window:
// a plain chunk or an index longer than the chunk goes from ISSUE straight to EMIT,
// a mismatched index start through ISSUE, CRD and CMP to EMIT. A superframe passes
// ISSUE, CRD and CMP, then per frame an RD and AC step per size byte and an EMIT
// that loads the result, and the input is ready again the cycle after the last result
// is loaded. Results leave through an output register, so a stalled master side
// only holds the sequencer when it has a new result to load. The window is never
// cleared; only bytes of the current chunk are read.
module vp9_superframe_index_parser
    import vp9sfi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] frame_size, [37:32] index_size, [39:38] zero
    output logic [1:0]  m_tuser,   // [0] is_superframe, [1] parse_error
    output logic        m_tlast    // last_of_run
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_CRD   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_AC    = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [WIN_AW-1:0] wp_reg, wp_next;
    logic [31:0]       count_reg, count_next;
    logic [7:0]        marker_reg, marker_next;
    logic [5:0]        total_reg, total_next;
    logic [WIN_AW-1:0] pos_reg, pos_next;
    logic [2:0]        fi_reg, fi_next;
    logic [1:0]        j_reg, j_next;
    logic [31:0]       acc_reg, acc_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [7:0]        win_mem [WINDOW_BYTES];
    logic [7:0]        rdata_reg;
    logic [WIN_AW-1:0] rd_addr;
    logic [WIN_AW-1:0] newest;
    logic [WIN_AW:0]   diff, wrap;
    logic              s_xfer, out_free, fin;
    logic [3:0]        nfr;
    logic [2:0]        len;
    logic [5:0]        total_w;
    logic [31:0]       acc_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // newest byte sits just behind the write pointer; walk back pos_reg entries
    assign newest  = (wp_reg == '0) ? WIN_AW'(WINDOW_BYTES - 1) : wp_reg - 1'b1;
    assign diff    = {1'b0, newest} - {1'b0, pos_reg};
    assign wrap    = diff + (WIN_AW+1)'(WINDOW_BYTES);
    assign rd_addr = diff[WIN_AW] ? wrap[WIN_AW-1:0] : diff[WIN_AW-1:0];

    assign nfr     = {1'b0, marker_reg[2:0] & FRAMES_MASK} + 4'd1;
    assign len     = {1'b0, marker_reg[4:3] & BYTES_MASK} + 3'd1;
    assign total_w = 6'(7'(MARKER_BYTES) + 7'(nfr) * 7'(len));
    assign fin     = (fi_reg == (marker_reg[2:0] & FRAMES_MASK));
    assign acc_sum = acc_reg | ({24'd0, rdata_reg} << {j_reg, 3'b000});

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            win_mem[wp_reg] <= s_tdata;
        end
        rdata_reg <= win_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        marker_next   = marker_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        fi_next       = fi_reg;
        j_next        = j_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    wp_next = (wp_reg == WIN_AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + 1'b1;
                    if (count_reg != 32'hffff_ffff) begin
                        count_next = count_reg + 32'd1;
                    end
                    if (s_tlast) begin
                        marker_next = s_tdata;
                        state_next  = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                total_next = total_w;
                if ((marker_reg & MARKER_MASK) != MARKER_VAL) begin
                    res_next   = '{frame_size: count_reg, index_size: 6'd0,
                                   is_superframe: 1'b0, parse_error: 1'b0,
                                   last_of_run: 1'b1};
                    state_next = ST_EMIT;
                end else if (count_reg < {26'd0, total_w}) begin
                    res_next   = '{frame_size: 32'd0, index_size: 6'd0,
                                   is_superframe: 1'b0, parse_error: 1'b1,
                                   last_of_run: 1'b1};
                    state_next = ST_EMIT;
                end else begin
                    pos_next   = WIN_AW'(total_w - 6'd1);
                    state_next = ST_CRD;
                end
            end
            ST_CRD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (rdata_reg != marker_reg) begin
                    res_next   = '{frame_size: 32'd0, index_size: 6'd0,
                                   is_superframe: 1'b0, parse_error: 1'b1,
                                   last_of_run: 1'b1};
                    state_next = ST_EMIT;
                end else begin
                    pos_next   = WIN_AW'(total_reg - MARKER_BYTES);
                    fi_next    = 3'd0;
                    j_next     = 2'd0;
                    acc_next   = 32'd0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_AC;
            end
            ST_AC: begin
                // assemble the little-endian size one byte at a time
                acc_next = acc_sum;
                pos_next = pos_reg - 1'b1;
                if (j_reg == (marker_reg[4:3] & BYTES_MASK)) begin
                    res_next   = '{frame_size: acc_sum,
                                   index_size: fin ? total_reg : 6'd0,
                                   is_superframe: 1'b1, parse_error: 1'b0,
                                   last_of_run: fin};
                    state_next = ST_EMIT;
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = ST_RD;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    if (res_reg.last_of_run) begin
                        count_next = 32'd0;
                        state_next = ST_IDLE;
                    end else begin
                        fi_next    = fi_reg + 3'd1;
                        j_next     = 2'd0;
                        acc_next   = 32'd0;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            count_reg    <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        marker_reg <= marker_next;
        total_reg  <= total_next;
        pos_reg    <= pos_next;
        fi_reg     <= fi_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.index_size, out_reg.frame_size};
    assign m_tuser  = {out_reg.parse_error, out_reg.is_superframe};
    assign m_tlast  = out_reg.last_of_run;

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata[31:0] == 32'd0) && !m_tuser[0])
        else $error("error result carries a size or superframe flag");

    a_idx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[37:32] != 6'd0) |-> m_tlast && m_tuser[0])
        else $error("index size on a result that is not the last superframe result");

    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRD || state_reg == ST_RD) |-> rd_addr < WIN_AW'(WINDOW_BYTES))
        else $error("window read address out of range");

    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free && res_reg.last_of_run |=>
            count_reg == 32'd0 && s_tready)
        else $error("byte count not cleared at end of chunk");

endmodule

// ----- bench/vp9sfi_size_checker.sv -----
// Result checker for the VP9 superframe index parser bench.
// Tracks the chunk tail and byte count, predicts each frame-size transfer and
// compares it with the master side. Depends on vp9sfi_pkg (constants, res_t).
`timescale 1ns / 1ps

module vp9sfi_size_checker
    import vp9sfi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] frame_size, [37:32] index_size, [39:38] zero
    input  logic [1:0]  m_tuser,   // [0] is_superframe, [1] parse_error
    input  logic        m_tlast,   // last_of_run
    output int          mismatch_count,
    output int          results_due
);

    logic [7:0]  chunk_tail [WINDOW_BYTES];   // newest byte at index 0
    logic [31:0] chunk_len;
    res_t        frame_sizes_due [$];

    function automatic res_t pack_result(input logic [31:0] size, input logic [5:0] idx,
                                         input logic sf, input logic err, input logic fin);
        res_t r;
        r.frame_size    = size;
        r.index_size    = idx;
        r.is_superframe = sf;
        r.parse_error   = err;
        r.last_of_run   = fin;
        return r;
    endfunction

    // Shift one byte into the tail; on the final byte walk the index.
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  marker;
        logic [31:0] count;
        logic [31:0] size;
        int          nframes;
        int          nbytes;
        int          span;
        int          pos;
        for (int i = WINDOW_BYTES - 1; i > 0; i--)
            chunk_tail[i] = chunk_tail[i-1];
        chunk_tail[0] = b;
        if (chunk_len != '1)
            chunk_len++;
        if (!fin)
            return;

        count     = chunk_len;
        chunk_len = '0;
        marker    = chunk_tail[0];
        if ((marker & MARKER_MASK) != MARKER_VAL) begin
            frame_sizes_due.push_back(pack_result(count, '0, 1'b0, 1'b0, 1'b1));
            return;
        end

        nframes = int'(marker & 8'(FRAMES_MASK)) + 1;
        nbytes  = int'((marker >> 3) & 8'(BYTES_MASK)) + 1;
        span    = int'(MARKER_BYTES) + nframes * nbytes;
        // check the length first so that no byte from an earlier chunk is looked at
        if (count < 32'(span) || span > WINDOW_BYTES || chunk_tail[span-1] != marker) begin
            frame_sizes_due.push_back(pack_result('0, '0, 1'b0, 1'b1, 1'b1));
            return;
        end

        pos = span - 2;
        for (int f = 0; f < nframes; f++) begin
            size = '0;
            for (int j = 0; j < nbytes; j++) begin
                size |= 32'(chunk_tail[pos]) << (8 * j);
                pos--;
            end
            if (f == nframes - 1)
                frame_sizes_due.push_back(pack_result(size, 6'(span), 1'b1, 1'b0, 1'b1));
            else
                frame_sizes_due.push_back(pack_result(size, '0, 1'b1, 1'b0, 1'b0));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            chunk_len      = '0;
            mismatch_count = 0;
            frame_sizes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_sizes_due.size() == 0) begin
                    $error("frame size transfer 0x%0h with nothing expected", m_tdata);
                    mismatch_count++;
                end else begin
                    want = frame_sizes_due.pop_front();
                    check_field("frame_size", want.frame_size, m_tdata[31:0]);
                    check_field("index_size", 32'(want.index_size), 32'(m_tdata[37:32]));
                    check_field("tdata_pad", '0, 32'(m_tdata[39:38]));
                    check_field("is_superframe", 32'(want.is_superframe), 32'(m_tuser[0]));
                    check_field("parse_error", 32'(want.parse_error), 32'(m_tuser[1]));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
        end
        results_due = frame_sizes_due.size();
    end

endmodule

// ----- bench/vp9_superframe_index_parser_tb.sv -----
// Top of the VP9 superframe index parser bench: clock, reset, chunk stimulus,
// receiver stalls, watchdog and verdict. Depends on vp9sfi_pkg, the parser and
// vp9sfi_size_checker.
`timescale 1ns / 1ps

module vp9_superframe_index_parser_tb
    import vp9sfi_pkg::*;
();

    localparam int BYTE_TARGET  = 170;    // directed and random chunks, at least 170 bytes
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE_TICKS = 150;    // longest index walk: 8 frames of 4-byte sizes

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;    // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] frame_size, [37:32] index_size, [39:38] zero
    logic [1:0]  m_tuser;    // [0] is_superframe, [1] parse_error
    logic        m_tlast;    // last_of_run

    int         mismatch_count;
    int         results_due;
    int         hold_requests;
    int         burst_left;
    int         bytes_sent;
    int         idle_cycles;
    logic [7:0] chunk_q [$];

    vp9_superframe_index_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    vp9sfi_size_checker size_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one byte; open a new burst, after a random gap, when the old one runs out.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(3, 0) == 0 ? $urandom_range(40, 10)
                                                   : $urandom_range(6, 1);
            gap = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(5, 1);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_chunk();
        foreach (chunk_q[i])
            send_byte(chunk_q[i], i == chunk_q.size() - 1);
        chunk_q.delete();
    endtask

    task automatic add_random(input int n);
        repeat (n) chunk_q.push_back(8'($urandom));
    endtask

    // Plain chunk: the final byte never carries the superframe marker bits.
    task automatic add_plain(input int len);
        logic [7:0] b;
        add_random(len - 1);
        do b = 8'($urandom); while ((b & MARKER_MASK) == MARKER_VAL);
        chunk_q.push_back(b);
    endtask

    function automatic logic [7:0] index_marker(input int nframes, input int nbytes);
        return MARKER_VAL | ((8'(nbytes - 1) & 8'(BYTES_MASK)) << 3)
                          | (8'(nframes - 1) & 8'(FRAMES_MASK));
    endfunction

    // Payload bytes, then marker, little-endian sizes and marker again.
    task automatic add_superframe(input int lead, input int nframes, input int nbytes,
                                  input bit bad_start);
        logic [7:0]  marker;
        logic [31:0] size;
        marker = index_marker(nframes, nbytes);
        add_random(lead);
        chunk_q.push_back(bad_start ? marker ^ 8'($urandom_range(255, 1)) : marker);
        repeat (nframes) begin
            case ($urandom_range(3, 0))
                0:       size = '0;
                1:       size = '1;
                default: size = $urandom;
            endcase
            for (int j = 0; j < nbytes; j++)
                chunk_q.push_back(size[8*j +: 8]);
        end
        chunk_q.push_back(marker);
    endtask

    // Marker byte at the end of a chunk too short to hold its index.
    task automatic add_truncated(input int nframes, input int nbytes);
        add_random($urandom_range(int'(MARKER_BYTES) + nframes * nbytes - 2, 0));
        chunk_q.push_back(index_marker(nframes, nbytes));
    endtask

    // Drop valid and hold until every predicted result has left the block.
    task automatic pause_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    initial begin : receiver
        rx_mode_e mode;
        int       seg_left;
        int       held;
        int       holds_done;
        m_tready   = 1'b0;
        seg_left   = 0;
        held       = 0;
        holds_done = 0;
        mode       = RX_OPEN;
        forever begin
            @(negedge aclk);
            if (holds_done < hold_requests) begin
                m_tready <= 1'b0;
                held++;
                if (held == HOLD_CYCLES) begin
                    holds_done++;
                    held = 0;
                end
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(80, 20);
                    mode     = rx_mode_e'($urandom_range(3, 0));
                end
                seg_left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= 1'($urandom);
                    RX_SPARSE: m_tready <= ($urandom_range(9, 0) == 0);
                    RX_TOGGLE: m_tready <= 1'(seg_left);
                    default:   m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[vp9_superframe_index_parser] ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        bit drained_mid;
        int kind;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        hold_requests = 0;
        burst_left    = 0;
        bytes_sent    = 0;
        drained_mid   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one-byte chunks: all zeros, all ones, lone marker (index longer than chunk)
        chunk_q.push_back(8'h00);
        send_chunk();
        chunk_q.push_back(8'hff);
        send_chunk();
        chunk_q.push_back(MARKER_VAL);
        send_chunk();
        add_superframe(0, 1, 1, 1'b0);     // index alone, smallest
        send_chunk();
        add_superframe(1, 2, 2, 1'b1);     // mismatched index start
        send_chunk();
        add_superframe(0, 1, 4, 1'b0);     // widest size field
        send_chunk();
        add_plain(4);
        send_chunk();
        pause_for_drain();

        // long receiver hold while the sender keeps offering a full-window index
        @(posedge aclk);
        hold_requests++;
        add_superframe(0, 8, 4, 1'b0);
        send_chunk();
        add_superframe(2, 3, 2, 1'b0);
        send_chunk();

        while (bytes_sent < BYTE_TARGET) begin
            if (!drained_mid && bytes_sent > BYTE_TARGET / 2) begin
                pause_for_drain();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(99, 0);
            if (kind < 60)
                add_superframe($urandom_range(3, 0), $urandom_range(8, 1),
                               $urandom_range(4, 1), 1'b0);
            else if (kind < 75)
                add_plain($urandom_range(6, 1));
            else if (kind < 85)
                add_superframe($urandom_range(2, 0), $urandom_range(8, 1),
                               $urandom_range(4, 1), 1'b1);
            else if (kind < 90)
                add_truncated($urandom_range(8, 1), $urandom_range(4, 1));
            else
                add_random($urandom_range(12, 1));
            send_chunk();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("[vp9_superframe_index_parser] OK");
        else
            $display("[vp9_superframe_index_parser] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/vp9sfi_pkg.sv
rtl/core/vp9_superframe_index_parser.sv
bench/vp9sfi_size_checker.sv
bench/vp9_superframe_index_parser_tb.sv
